// ===== rtl/dbd_pkg.sv =====
// ----------------------------------------------------------------------------
// dbd_pkg: shared constants and calendar tables
// Field widths, packing offsets and month tables for the day-count unit.
// ----------------------------------------------------------------------------
package dbd_pkg;

  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_W      = 16;
  localparam int ORD_W       = 25;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;

  localparam int FD_LO = 0;
  localparam int FM_LO = FD_LO + DAY_W;
  localparam int FY_LO = FM_LO + MONTH_W;
  localparam int SD_LO = FY_LO + YEAR_W;
  localparam int SM_LO = SD_LO + DAY_W;
  localparam int SY_LO = SM_LO + MONTH_W;

  localparam int TUSER_LATER = 0;
  localparam int TUSER_VALID = 1;

  localparam logic [8:0]       DAYS_YEAR  = 9'd365;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      MONTH_FEB:                                   len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the whole months before the given one
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month,
                                             input logic leap);
    logic [8:0] n;
    case (month)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    if (leap && (month > MONTH_FEB)) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

endpackage

// ===== rtl/days_between_dates_unit.sv =====
// An input transfer passes through the input register, the ordinal
// register and the result register before its result is offered.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits on out_tready.
// Reset: rst_n synchronous, active low; clears all stage valid flags.
// ----------------------------------------------------------------------------
// days_between_dates_unit: day distance between two calendar dates
// Converts both dates to ordinal day numbers (leap year every fourth year)
// and returns their absolute difference, an ordering flag and a valid flag.
// ----------------------------------------------------------------------------
module days_between_dates_unit
  import dbd_pkg::*;
#(
  parameter int YEAR_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // first_day, first_month, first_year, second_day, second_month, second_year
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // day_count
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // second_later, dates_valid
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  logic              en;
  logic              s1_vld_r;
  date_t             s1_a_r, s1_b_r;
  logic              s2_vld_r;
  logic              s2_ok_r;
  logic [ORD_W-1:0]  s2_a_r, s2_b_r;
  logic              out_vld_r;
  logic [ORD_W-1:0]  cnt_r;
  logic              later_r;
  logic              ok_r;

  date_t             a_in, b_in;
  logic              ok_a, ok_b;
  logic [ORD_W-1:0]  ord_a, ord_b;
  logic [ORD_W-1:0]  cnt_nxt;
  logic              later_nxt;

  function automatic logic [YEAR_W-1:0] year_bits(input logic [YEAR_W-1:0] y);
    return YEAR_W'(y[YEAR_WIDTH-1:0]);
  endfunction

  function automatic logic date_ok(input date_t d);
    logic [YEAR_W-1:0] y;
    y = year_bits(d.year);
    return (d.day != '0) && (d.month != '0) && (y != '0) && (d.month <= MONTH_DEC)
           && (d.day <= month_len(d.month, y[1:0] == 2'b00));
  endfunction

  function automatic logic [ORD_W-1:0] ordinal(input date_t d);
    logic [YEAR_W-1:0] y;
    logic [ORD_W-1:0]  p;
    y = year_bits(d.year);
    p = ORD_W'(y - YEAR_W'(1));
    return p * ORD_W'(DAYS_YEAR) + (p >> 2)
           + ORD_W'(days_before(d.month, y[1:0] == 2'b00)) + ORD_W'(d.day);
  endfunction

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  assign a_in = '{day:   in_tdata[FD_LO +: DAY_W],
                  month: in_tdata[FM_LO +: MONTH_W],
                  year:  in_tdata[FY_LO +: YEAR_W]};
  assign b_in = '{day:   in_tdata[SD_LO +: DAY_W],
                  month: in_tdata[SM_LO +: MONTH_W],
                  year:  in_tdata[SY_LO +: YEAR_W]};

  always_comb begin
    ok_a  = date_ok(s1_a_r);
    ok_b  = date_ok(s1_b_r);
    ord_a = ordinal(s1_a_r);
    ord_b = ordinal(s1_b_r);
  end

  always_comb begin
    later_nxt = 1'b0;
    cnt_nxt   = '0;
    if (s2_ok_r) begin
      later_nxt = s2_b_r > s2_a_r;
      cnt_nxt   = later_nxt ? (s2_b_r - s2_a_r) : (s2_a_r - s2_b_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_tvalid;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r  <= a_in;
      s1_b_r  <= b_in;
      s2_ok_r <= ok_a && ok_b;
      s2_a_r  <= ord_a;
      s2_b_r  <= ord_b;
      cnt_r   <= cnt_nxt;
      later_r <= later_nxt;
      ok_r    <= s2_ok_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'(cnt_r);
  always_comb begin
    out_tuser              = '0;
    out_tuser[TUSER_LATER] = later_r;
    out_tuser[TUSER_VALID] = ok_r;
  end

endmodule

// ===== rtl/dbd_checker.sv =====
// ----------------------------------------------------------------------------
// dbd_checker: port-level checks for the day-count unit
// Watches the result channel for reset, hold and result consistency.
// ----------------------------------------------------------------------------
module dbd_checker
  import dbd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[TUSER_VALID] |-> out_tdata == '0 && !out_tuser[TUSER_LATER])
    else $error("invalid dates gave nonzero result");

  a_later_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[TUSER_LATER] |-> out_tdata != '0 && out_tuser[TUSER_VALID])
    else $error("later flag with zero count");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:ORD_W] == '0)
    else $error("padding bits set");

endmodule

bind days_between_dates_unit dbd_checker u_dbd_checker (.*);

// ===== tb/tb_days_between_dates_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_days_between_dates_unit: stream test of the day-count unit
// Sends pairs of dates, some well formed and some broken. A scoreboard works
// out each expected day span and compares it with the results in order.
// Flow control runs through several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module tb_days_between_dates_unit;
  import dbd_pkg::*;

  localparam int TB_YEAR_WIDTH    = 16;
  localparam int RANDOM_PER_PHASE = 425;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int TAIL_CYCLES      = 8;

  class day_span_board #(int YW = 16);
    localparam int unsigned YMASK = (32'd1 << YW) - 32'd1;

    typedef struct {
      logic [ORD_W-1:0] count;
      logic             later;
      logic             valid;
    } day_span_t;

    day_span_t   span_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned valid_seen;
    int unsigned later_seen;

    function new();
      mismatches = 0;
      checked    = 0;
      valid_seen = 0;
      later_seen = 0;
    endfunction

    function int unsigned month_length(int unsigned month, int unsigned year);
      case (month)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        MONTH_FEB:             return ((year % 4) == 0) ? 29 : 28;
        default:               return 0;
      endcase
    endfunction

    function bit date_ok(date_t x);
      int unsigned yr;
      yr = x.year & YMASK;
      if (x.day == 0 || x.month == 0 || yr == 0 || x.month > MONTH_DEC) return 1'b0;
      return x.day <= month_length(x.month, yr);
    endfunction

    function int unsigned ordinal(date_t x);
      int unsigned yr;
      int unsigned prior;
      int unsigned n;
      yr    = x.year & YMASK;
      prior = yr - 1;
      n     = prior * 365 + prior / 4;
      for (int unsigned mm = 1; mm < x.month; mm++) n += month_length(mm, yr);
      return n + x.day;
    endfunction

    function day_span_t predict(date_t a, date_t b);
      day_span_t   s;
      int unsigned oa;
      int unsigned ob;
      s.count = '0;
      s.later = 1'b0;
      s.valid = 1'b0;
      if (date_ok(a) && date_ok(b)) begin
        oa      = ordinal(a);
        ob      = ordinal(b);
        s.valid = 1'b1;
        if (ob > oa) begin
          s.later = 1'b1;
          s.count = ORD_W'(ob - oa);
        end else begin
          s.count = ORD_W'(oa - ob);
        end
      end
      return s;
    endfunction

    function void note_input(date_t a, date_t b);
      span_q.push_back(predict(a, b));
    endfunction

    function int unsigned pending();
      return span_q.size();
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic [OUT_TUSER_W-1:0] tuser);
      day_span_t exp_s;
      if (span_q.size() == 0) begin
        $error("result with no pending transfer: tdata=%0h tuser=%0h", tdata, tuser);
        mismatches++;
        return;
      end
      exp_s = span_q.pop_front();
      checked++;
      if (exp_s.valid) valid_seen++;
      if (exp_s.later) later_seen++;
      if (tdata[ORD_W-1:0] !== exp_s.count) begin
        $error("day_count: expected %0d, got %0d", exp_s.count, tdata[ORD_W-1:0]);
        mismatches++;
      end
      if (tdata[OUT_TDATA_W-1:ORD_W] !== '0) begin
        $error("tdata pad: expected 0, got %0h", tdata[OUT_TDATA_W-1:ORD_W]);
        mismatches++;
      end
      if (tuser[TUSER_LATER] !== exp_s.later) begin
        $error("second_later: expected %0b, got %0b", exp_s.later, tuser[TUSER_LATER]);
        mismatches++;
      end
      if (tuser[TUSER_VALID] !== exp_s.valid) begin
        $error("dates_valid: expected %0b, got %0b", exp_s.valid, tuser[TUSER_VALID]);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned cycle_count   = 0;

  day_span_board #(TB_YEAR_WIDTH) board;

  days_between_dates_unit #(
    .YEAR_WIDTH(TB_YEAR_WIDTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_result(out_tdata, out_tuser);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic date_t mk(int unsigned d, int unsigned m, int unsigned y);
    date_t x;
    x.day   = DAY_W'(d);
    x.month = MONTH_W'(m);
    x.year  = YEAR_W'(y);
    return x;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_dates(date_t a, date_t b);
    logic [IN_TDATA_W-1:0] v;
    v                    = '0;
    v[FD_LO +: DAY_W]    = a.day;
    v[FM_LO +: MONTH_W]  = a.month;
    v[FY_LO +: YEAR_W]   = a.year;
    v[SD_LO +: DAY_W]    = b.day;
    v[SM_LO +: MONTH_W]  = b.month;
    v[SY_LO +: YEAR_W]   = b.year;
    return v;
  endfunction

  function automatic int unsigned pick_year();
    case ($urandom_range(3))
      0:       return $urandom_range(1, 12);
      1:       return $urandom_range(65520, 65535);
      2:       return $urandom_range(1, 16383) * 4;
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  function automatic date_t good_date(int unsigned y);
    int unsigned m;
    int unsigned len;
    int unsigned d;
    m   = $urandom_range(1, 12);
    len = board.month_length(m, y);
    case ($urandom_range(5))
      0:       d = 1;
      1:       d = len;
      default: d = $urandom_range(1, len);
    endcase
    return mk(d, m, y);
  endfunction

  function automatic date_t noise_date();
    return mk($urandom_range(31), $urandom_range(15), $urandom_range(65535));
  endfunction

  function automatic date_t break_date(date_t x);
    date_t y;
    y = x;
    case ($urandom_range(4))
      0: y.day = '0;
      1: y.month = '0;
      2: y.year = '0;
      3: y.month = MONTH_W'($urandom_range(13, 15));
      default: begin
        if ($urandom_range(1) != 0 || x.year == 0) begin
          y.month = MONTH_FEB;
          y.day   = DAY_W'($urandom_range(board.month_length(MONTH_FEB, x.year) + 1, 31));
        end else begin
          case ($urandom_range(3))
            0:       y.month = 4'd4;
            1:       y.month = 4'd6;
            2:       y.month = 4'd9;
            default: y.month = 4'd11;
          endcase
          y.day = 5'd31;
        end
      end
    endcase
    return y;
  endfunction

  task automatic send_pair(date_t a, date_t b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_dates(a, b);
    do @(posedge clk); while (!in_tready);
    board.note_input(a, b);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
  endtask

  task automatic send_random();
    date_t       a;
    date_t       b;
    int unsigned kind;
    int          ny;
    kind = $urandom_range(99);
    a    = good_date(pick_year());
    if (kind < 15) begin
      a = noise_date();
      b = noise_date();
    end else if (kind < 30) begin
      b = good_date(a.year);
    end else if (kind < 45) begin
      ny = int'(a.year) + int'($urandom_range(0, 6)) - 3;
      if (ny < 1) ny = 1;
      if (ny > 65535) ny = 65535;
      b = good_date(ny);
    end else if (kind < 57) begin
      b = good_date(pick_year());
      if ($urandom_range(1) != 0) a = break_date(a);
      else b = break_date(b);
    end else begin
      b = good_date(pick_year());
    end
    if ($urandom_range(1) != 0) send_pair(a, b);
    else send_pair(b, a);
  endtask

  task automatic run_directed();
    send_pair(mk(1, 1, 1), mk(1, 1, 1));
    send_pair(mk(1, 1, 1), mk(31, 12, 65535));
    send_pair(mk(31, 12, 65535), mk(1, 1, 1));
    send_pair(mk(29, 2, 4), mk(1, 3, 4));
    send_pair(mk(29, 2, 5), mk(1, 1, 5));
    send_pair(mk(30, 2, 8), mk(1, 1, 1));
    send_pair(mk(28, 2, 7), mk(1, 3, 7));
    send_pair(mk(0, 5, 100), mk(1, 1, 1));
    send_pair(mk(1, 0, 100), mk(1, 1, 1));
    send_pair(mk(1, 1, 0), mk(1, 1, 1));
    send_pair(mk(1, 13, 10), mk(1, 1, 1));
    send_pair(mk(1, 1, 1), mk(1, 15, 10));
    send_pair(mk(1, 1, 2000), mk(31, 4, 2000));
    send_pair(mk(31, 1, 2000), mk(31, 12, 2000));
    send_pair(mk(31, 12, 3), mk(1, 1, 4));
    send_pair(mk(1, 1, 65532), mk(31, 12, 65535));
    send_pair(mk(31, 15, 65535), mk(31, 15, 65535));
    send_pair(mk(0, 0, 0), mk(0, 0, 0));
    send_pair(mk(15, 6, 1900), mk(15, 6, 1900));
    send_pair(mk(1, 3, 100), mk(29, 2, 100));
    send_pair(mk(30, 11, 1999), mk(1, 12, 1999));
    send_pair(mk(31, 12, 65535), mk(30, 12, 65535));
  endtask

  initial begin
    board = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct   = 70;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 70;
        end
        default: begin
          in_idle_pct   = 36;
          out_stall_pct = 36;
        end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        // hold off until the pipeline has emptied
        if (ph == 2 && i == RANDOM_PER_PHASE / 2) drain_results();
        send_random();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d date pairs: %0d with both dates valid, %0d with the second later,",
             board.checked, board.valid_seen, board.later_seen);
    $display("through free-running, sender-idle, receiver-stall and mixed flow control.");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dbd_pkg.sv
rtl/days_between_dates_unit.sv
rtl/dbd_checker.sv
tb/tb_days_between_dates_unit.sv
